FILE: rtl/core/ir_sensor_frame_parser_assert.svh
// Assertion macros for the IR sensor frame parser.
// Included by the modules that check their own logic; no other dependencies.
`ifndef IR_SENSOR_FRAME_PARSER_ASSERT_SVH
`define IR_SENSOR_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTH
`define IRSFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("irsfp assertion failed");
`define IRSFP_NEVER(lbl, clk, rst_n, cond) \
    `IRSFP_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define IRSFP_ASSERT(lbl, clk, rst_n, prop)
`define IRSFP_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/core/irsfp_pkg.sv
// Shared types, constants and helper functions of the IR sensor frame parser.
// No dependencies.
package irsfp_pkg;

    localparam int FRAME_CAPACITY_DEF = 64;
    localparam int QUEUE_DEPTH        = 2;
    localparam logic [15:0] AGE_MAX   = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // config register indexes
    localparam logic CFG_SENSOR_REVERSE = 1'b0;
    localparam logic CFG_FRAME_TIMEOUT  = 1'b1;

    typedef enum logic [3:0] {
        SYM_TICK,
        SYM_DOLLAR,
        SYM_TERM,
        SYM_D,
        SYM_COMMA,
        SYM_X,
        SYM_COLON,
        SYM_ZERO,
        SYM_ONE,
        SYM_DIGIT,
        SYM_OTHER
    } t_sym;

    typedef struct packed {
        t_sym        sym;
        logic [15:0] elapsed;
    } t_item;

    function automatic t_sym classify(input logic command, input logic [7:0] c);
        t_sym s;
        if (command)
            s = SYM_TICK;
        else if (c == CH_DOLLAR)
            s = SYM_DOLLAR;
        else if (c == CH_HASH || c == CH_LF || c == CH_CR)
            s = SYM_TERM;
        else if (c == CH_D)
            s = SYM_D;
        else if (c == CH_COMMA)
            s = SYM_COMMA;
        else if (c == CH_X)
            s = SYM_X;
        else if (c == CH_COLON)
            s = SYM_COLON;
        else if (c == CH_ZERO)
            s = SYM_ZERO;
        else if (c == CH_ONE)
            s = SYM_ONE;
        else if (c > CH_ONE && c <= CH_NINE)
            s = SYM_DIGIT;
        else
            s = SYM_OTHER;
        return s;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[7 - i] = v[i];
        return r;
    endfunction

endpackage

FILE: rtl/core/ir_sensor_frame_parser.sv
// IR sensor frame parser top level: front classifier, queue, back stage.
// Depends on irsfp_pkg, irsfp_front, irsfp_queue, irsfp_back.
//
// Takes received bytes and millisecond ticks one beat at a time and returns
// one result beat per input beat, in order. Frames read "$D,x<digits>:V,..."
// with eight fields; '#', CR or LF ends one, and a frame whose eighth value
// was seen latches the sensor values, clears the age and bumps the frame
// count. Sustained rate is one beat per cycle while the output is not held
// back; a result passes through the front register, the two-entry queue and
// the output register. Config writes take effect at once and are meant to
// be made while no beat is in flight.
module ir_sensor_frame_parser
    import irsfp_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_tick_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_done,
    output logic [7:0]  o_black_mask,
    output logic [7:0]  o_line_mask,
    output logic [31:0] o_frame_count,
    output logic        o_data_fresh
);

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  queue_valid;
    logic  queue_ready;
    t_item queue_item;

    irsfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .i_tick_ms    (i_tick_ms),
        .o_valid      (front_valid),
        .o_item       (front_item),
        .i_ready      (front_ready)
    );

    irsfp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    irsfp_back #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (queue_valid),
        .o_ready       (queue_ready),
        .i_item        (queue_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_done  (o_frame_done),
        .o_black_mask  (o_black_mask),
        .o_line_mask   (o_line_mask),
        .o_frame_count (o_frame_count),
        .o_data_fresh  (o_data_fresh)
    );

endmodule

FILE: rtl/core/irsfp_front.sv
// Front stage: accepts input beats and classifies them into symbols.
// Depends on irsfp_pkg.
module irsfp_front
    import irsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_tick_ms,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_ready
);

    logic  r_valid;
    t_item r_item;

    assign o_in_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.sym     <= classify(i_command, i_rx_byte);
            r_item.elapsed <= i_tick_ms;
        end
    end

endmodule

FILE: rtl/core/irsfp_queue.sv
// Short queue of classified beats between front and back stages.
// Depends on irsfp_pkg.
module irsfp_queue
    import irsfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push)
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (pop)
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (push && !pop)
                r_count <= r_count + 1'b1;
            else if (pop && !push)
                r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wr_ptr] <= i_push_item;
    end

endmodule

FILE: rtl/core/irsfp_back.sv
// Back stage: frame grammar, latched sensor values, age and frame counters,
// config registers and the output register. Depends on irsfp_pkg.
`include "ir_sensor_frame_parser_assert.svh"
module irsfp_back
    import irsfp_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_done,
    output logic [7:0]  o_black_mask,
    output logic [7:0]  o_line_mask,
    output logic [31:0] o_frame_count,
    output logic        o_data_fresh
);

    localparam int CNT_W = $clog2(FRAME_CAPACITY);

    typedef enum logic [2:0] {
        PH_D,
        PH_COMMA,
        PH_X,
        PH_DIGITS,
        PH_VALUE,
        PH_SEP
    } t_phase;

    logic             r_sensor_reverse;
    logic [15:0]      r_frame_timeout;

    logic             r_hunting,   n_hunting;
    logic [CNT_W-1:0] r_stored,    n_stored;
    t_phase           r_phase,     n_phase;
    logic [2:0]       r_field,     n_field;
    logic [7:0]       r_partial,   n_partial;
    logic             r_complete,  n_complete;
    logic             r_failed,    n_failed;
    logic [7:0]       r_latched,   n_latched;
    logic             r_seen,      n_seen;
    logic [15:0]      r_age,       n_age;
    logic [31:0]      r_frames,    n_frames;
    logic             n_done;
    logic [16:0]      age_sum;
    logic [7:0]       black;

    logic             r_out_valid;
    logic             r_done;
    logic [7:0]       r_black;
    logic             r_fresh;
    logic             pop;

    assign o_ready       = !r_out_valid || i_out_ready;
    assign pop           = i_valid && o_ready;
    assign o_out_valid   = r_out_valid;
    assign o_frame_done  = r_done;
    assign o_black_mask  = r_black;
    assign o_line_mask   = ~r_black;
    assign o_frame_count = r_frames;
    assign o_data_fresh  = r_fresh;

    assign age_sum = {1'b0, r_age} + {1'b0, i_item.elapsed};

    always_comb begin
        n_hunting  = r_hunting;
        n_stored   = r_stored;
        n_phase    = r_phase;
        n_field    = r_field;
        n_partial  = r_partial;
        n_complete = r_complete;
        n_failed   = r_failed;
        n_latched  = r_latched;
        n_seen     = r_seen;
        n_age      = r_age;
        n_frames   = r_frames;
        n_done     = 1'b0;

        if (i_item.sym == SYM_TICK) begin
            if (r_age != AGE_MAX)
                n_age = age_sum[16] ? AGE_MAX : age_sum[15:0];
        end else if (i_item.sym == SYM_DOLLAR) begin
            n_hunting  = 1'b0;
            n_stored   = CNT_W'(1);
            n_phase    = PH_D;
            n_field    = '0;
            n_partial  = '0;
            n_complete = 1'b0;
            n_failed   = 1'b0;
        end else if (!r_hunting) begin
            if (r_stored < CNT_W'(FRAME_CAPACITY - 1)) begin
                n_stored = r_stored + 1'b1;
                if (!r_complete && !r_failed) begin
                    case (r_phase)
                        PH_D: begin
                            if (i_item.sym == SYM_D) n_phase = PH_COMMA;
                            else n_failed = 1'b1;
                        end
                        PH_COMMA: begin
                            if (i_item.sym == SYM_COMMA) n_phase = PH_X;
                            else n_failed = 1'b1;
                        end
                        PH_X: begin
                            if (i_item.sym == SYM_X) n_phase = PH_DIGITS;
                            else n_failed = 1'b1;
                        end
                        PH_DIGITS: begin
                            if (i_item.sym == SYM_COLON)
                                n_phase = PH_VALUE;
                            else if (i_item.sym != SYM_ZERO && i_item.sym != SYM_ONE &&
                                     i_item.sym != SYM_DIGIT)
                                n_failed = 1'b1;
                        end
                        PH_VALUE: begin
                            if (i_item.sym == SYM_ZERO || i_item.sym == SYM_ONE) begin
                                if (i_item.sym == SYM_ONE)
                                    n_partial[r_field] = 1'b1;
                                if (r_field == 3'd7) n_complete = 1'b1;
                                else n_phase = PH_SEP;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        PH_SEP: begin
                            if (i_item.sym == SYM_COMMA) begin
                                n_field = r_field + 3'd1;
                                n_phase = PH_X;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        default: n_failed = 1'b1;
                    endcase
                end
            end
            if (i_item.sym == SYM_TERM) begin
                if (n_complete) begin
                    n_latched = n_partial;
                    n_seen    = 1'b1;
                    n_age     = '0;
                    n_frames  = r_frames + 32'd1;
                    n_done    = 1'b1;
                end
                n_hunting = 1'b1;
                n_stored  = '0;
            end
        end

        black = r_sensor_reverse ? n_latched : reverse8(n_latched);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_reverse <= 1'b0;
            r_frame_timeout  <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SENSOR_REVERSE: r_sensor_reverse <= i_cfg_wdata[0];
                CFG_FRAME_TIMEOUT:  r_frame_timeout  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting   <= 1'b1;
            r_stored    <= '0;
            r_phase     <= PH_D;
            r_field     <= '0;
            r_partial   <= '0;
            r_complete  <= 1'b0;
            r_failed    <= 1'b0;
            r_latched   <= '0;
            r_seen      <= 1'b0;
            r_age       <= AGE_MAX;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_hunting  <= n_hunting;
                r_stored   <= n_stored;
                r_phase    <= n_phase;
                r_field    <= n_field;
                r_partial  <= n_partial;
                r_complete <= n_complete;
                r_failed   <= n_failed;
                r_latched  <= n_latched;
                r_seen     <= n_seen;
                r_age      <= n_age;
                r_frames   <= n_frames;
            end
            if (o_ready)
                r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_done  <= n_done;
            r_black <= black;
            r_fresh <= n_seen && (n_age <= r_frame_timeout);
        end
    end

    `IRSFP_ASSERT(a_stored_bound, i_clk, i_rst_n, r_stored <= CNT_W'(FRAME_CAPACITY - 1))
    `IRSFP_NEVER(a_hunting_empty, i_clk, i_rst_n, r_hunting && r_stored != '0)
    `IRSFP_NEVER(a_complete_failed, i_clk, i_rst_n, r_complete && r_failed)
    `IRSFP_ASSERT(a_done_counts, i_clk, i_rst_n, (pop && n_done) |=> (r_frames == $past(r_frames) + 32'd1))
    `IRSFP_ASSERT(a_done_age, i_clk, i_rst_n, (pop && n_done) |=> (r_age == '0 && r_seen))

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for ir_sensor_frame_parser: random and directed byte/tick beats,
// a beat-level frame grammar predictor and an in-order result scoreboard.
// Depends on irsfp_pkg and the parser RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import irsfp_pkg::*;

    localparam int STORE_CAP   = FRAME_CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 240;

    typedef enum logic [2:0] {
        GR_D, GR_COMMA, GR_X, GR_DIGITS, GR_VALUE, GR_SEP
    } t_grammar_phase;

    typedef struct {
        logic        command;
        logic [7:0]  rx_byte;
        logic [15:0] tick_ms;
    } t_sensor_beat;

    typedef struct {
        logic        frame_done;
        logic [7:0]  black_mask;
        logic [7:0]  line_mask;
        logic [31:0] frame_count;
        logic        data_fresh;
    } t_sensor_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CFG_SENSOR_REVERSE;
    logic [15:0] cfg_data = '0;
    logic        in_vld = 1'b0;
    logic        in_cmd = 1'b0;
    logic [7:0]  in_byte = '0;
    logic [15:0] in_ms = '0;
    logic        out_rdy = 1'b0;
    logic        o_in_ready, o_out_valid, o_frame_done, o_data_fresh;
    logic [7:0]  o_black_mask, o_line_mask;
    logic [31:0] o_frame_count;

    ir_sensor_frame_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_we),
        .i_cfg_index  (cfg_idx),
        .i_cfg_wdata  (cfg_data),
        .i_in_valid   (in_vld),
        .o_in_ready   (o_in_ready),
        .i_command    (in_cmd),
        .i_rx_byte    (in_byte),
        .i_tick_ms    (in_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_rdy),
        .o_frame_done (o_frame_done),
        .o_black_mask (o_black_mask),
        .o_line_mask  (o_line_mask),
        .o_frame_count(o_frame_count),
        .o_data_fresh (o_data_fresh)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic           mdl_reverse = 1'b0;
    logic [15:0]    mdl_timeout = TIMEOUT_RESET;
    logic           mdl_hunting = 1'b1;
    int unsigned    mdl_stored = 0;
    t_grammar_phase mdl_phase = GR_D;
    logic [2:0]     mdl_field = '0;
    logic [7:0]     mdl_partial = '0;
    logic           mdl_complete = 1'b0;
    logic           mdl_failed = 1'b0;
    logic [7:0]     mdl_latched = '0;
    logic           mdl_seen = 1'b0;
    logic [15:0]    mdl_age = AGE_MAX;
    logic [31:0]    mdl_frames = '0;

    t_sensor_beat   tx_beats[$];
    t_sensor_report predicted_reports[$];
    int             queued_beats = 0;
    int             cycle_cnt = 0;
    int             mismatches = 0;
    int             hold_cnt = 0;
    bit             beat_taken = 1'b0;
    t_sensor_report want, got;
    t_sensor_beat   cur_beat;

    wire calm = (cycle_cnt % 2000) >= 1500;

    task automatic parse_sensor_beat(input t_sensor_beat b, output t_sensor_report r);
        logic [7:0]  c;
        logic [7:0]  black;
        logic [16:0] sum;
        logic        done;
        c = b.rx_byte;
        done = 1'b0;
        if (b.command == 1'b0) begin
            if (c == CH_DOLLAR) begin
                mdl_hunting = 1'b0;
                mdl_stored = 1;
                mdl_phase = GR_D;
                mdl_field = '0;
                mdl_partial = '0;
                mdl_complete = 1'b0;
                mdl_failed = 1'b0;
            end else if (!mdl_hunting) begin
                if (mdl_stored < STORE_CAP - 1) begin
                    mdl_stored++;
                    if (!mdl_complete && !mdl_failed) begin
                        case (mdl_phase)
                            GR_D: begin
                                if (c == CH_D) mdl_phase = GR_COMMA;
                                else mdl_failed = 1'b1;
                            end
                            GR_COMMA: begin
                                if (c == CH_COMMA) mdl_phase = GR_X;
                                else mdl_failed = 1'b1;
                            end
                            GR_X: begin
                                if (c == CH_X) mdl_phase = GR_DIGITS;
                                else mdl_failed = 1'b1;
                            end
                            GR_DIGITS: begin
                                if (c == CH_COLON) mdl_phase = GR_VALUE;
                                else if (c < CH_ZERO || c > CH_NINE) mdl_failed = 1'b1;
                            end
                            GR_VALUE: begin
                                if (c == CH_ZERO || c == CH_ONE) begin
                                    if (c == CH_ONE) mdl_partial[mdl_field] = 1'b1;
                                    if (mdl_field == 3'd7) mdl_complete = 1'b1;
                                    else mdl_phase = GR_SEP;
                                end else begin
                                    mdl_failed = 1'b1;
                                end
                            end
                            GR_SEP: begin
                                if (c == CH_COMMA) begin
                                    mdl_field = mdl_field + 3'd1;
                                    mdl_phase = GR_X;
                                end else begin
                                    mdl_failed = 1'b1;
                                end
                            end
                            default: mdl_failed = 1'b1;
                        endcase
                    end
                end
                if (c == CH_HASH || c == CH_LF || c == CH_CR) begin
                    if (mdl_complete) begin
                        mdl_latched = mdl_partial;
                        mdl_seen = 1'b1;
                        mdl_age = '0;
                        mdl_frames = mdl_frames + 32'd1;
                        done = 1'b1;
                    end
                    mdl_hunting = 1'b1;
                    mdl_stored = 0;
                end
            end
        end else if (mdl_age < AGE_MAX) begin
            sum = {1'b0, mdl_age} + {1'b0, b.tick_ms};
            mdl_age = sum[16] ? AGE_MAX : sum[15:0];
        end
        if (mdl_reverse) begin
            black = mdl_latched;
        end else begin
            for (int i = 0; i < 8; i++) black[7 - i] = mdl_latched[i];
        end
        r.frame_done  = done;
        r.black_mask  = black;
        r.line_mask   = ~black;
        r.frame_count = mdl_frames;
        r.data_fresh  = mdl_seen && (mdl_age <= mdl_timeout);
    endtask

    task automatic push_byte(input logic [7:0] c);
        t_sensor_beat b;
        b.command = 1'b0;
        b.rx_byte = c;
        b.tick_ms = 16'($urandom);
        tx_beats.push_back(b);
        queued_beats++;
    endtask

    task automatic push_tick(input logic [15:0] ms);
        t_sensor_beat b;
        b.command = 1'b1;
        b.rx_byte = 8'($urandom);
        b.tick_ms = ms;
        tx_beats.push_back(b);
        queued_beats++;
    endtask

    task automatic push_random_tick();
        logic [15:0] ms;
        case ($urandom_range(0, 9))
            0: ms = '0;
            1: ms = AGE_MAX;
            2, 3: ms = 16'($urandom);
            default: ms = 16'($urandom_range(1, 60));
        endcase
        push_tick(ms);
    endtask

    task automatic push_frame(input int max_digits, input bit junk_tail, input bit corrupt);
        logic [7:0] txt[$];
        int         pos;
        txt.push_back(CH_DOLLAR);
        txt.push_back(CH_D);
        txt.push_back(CH_COMMA);
        for (int f = 0; f < 8; f++) begin
            txt.push_back(CH_X);
            repeat ($urandom_range(0, max_digits))
                txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            txt.push_back(CH_COLON);
            txt.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
            if (f < 7) txt.push_back(CH_COMMA);
        end
        if (junk_tail)
            repeat ($urandom_range(1, 30)) txt.push_back(8'($urandom_range(8'h3b, 8'h7e)));
        if (corrupt) begin
            pos = $urandom_range(1, txt.size() - 1);
            txt[pos] = 8'($urandom);
        end
        case ($urandom_range(0, 2))
            0: txt.push_back(CH_HASH);
            1: txt.push_back(CH_LF);
            default: txt.push_back(CH_CR);
        endcase
        foreach (txt[k]) begin
            if ($urandom_range(0, 19) == 0) push_random_tick();
            push_byte(txt[k]);
        end
    endtask

    task automatic wait_idle();
        while (tx_beats.size() != 0 || in_vld || predicted_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SENSOR_REVERSE) mdl_reverse = data[0];
        else mdl_timeout = data;
    endtask

    initial begin
        int kind;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hunting: noise and terminators are ignored, no frame yet
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(CH_HASH);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_D);
        push_tick(AGE_MAX);
        push_tick(16'h0000);
        // restart, then a frame ending after its first value
        push_byte(CH_DOLLAR);
        push_byte(CH_DOLLAR);
        push_byte(CH_D);
        push_byte(CH_COMMA);
        push_byte(CH_X);
        push_byte(CH_COLON);
        push_byte(CH_ONE);
        push_byte(CH_HASH);
        // bad second character, then a bad first one
        push_byte(CH_DOLLAR);
        push_byte(CH_D);
        push_byte(8'h51);
        push_byte(CH_CR);
        push_byte(CH_DOLLAR);
        push_byte(CH_X);
        push_byte(CH_LF);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_SENSOR_REVERSE, 16'd1);
                    write_reg(CFG_FRAME_TIMEOUT, 16'd0);
                end
                1: begin
                    write_reg(CFG_SENSOR_REVERSE, 16'd0);
                    write_reg(CFG_FRAME_TIMEOUT, AGE_MAX);
                end
                2: begin
                    write_reg(CFG_SENSOR_REVERSE, 16'd1);
                    write_reg(CFG_FRAME_TIMEOUT, 16'($urandom_range(20, 300)));
                end
                default: begin
                    write_reg(CFG_SENSOR_REVERSE, 16'd0);
                    write_reg(CFG_FRAME_TIMEOUT, TIMEOUT_RESET);
                end
            endcase
            queued_beats = 0;
            while (queued_beats < PHASE_BEATS) begin
                kind = $urandom_range(0, 99);
                if (kind < 60) push_frame(2, $urandom_range(0, 4) == 0, 1'b0);
                else if (kind < 70) push_frame(2, 1'b0, 1'b1);
                else if (kind < 85) repeat ($urandom_range(1, 3)) push_random_tick();
                else if (kind < 95) repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
                else push_frame($urandom_range(0, 1) ? 6 : 3, 1'b1, 1'b0);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && predicted_reports.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_vld || beat_taken)) begin
            if (tx_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
                cur_beat = tx_beats.pop_front();
                in_vld <= 1'b1;
                in_cmd <= cur_beat.command;
                in_byte <= cur_beat.rx_byte;
                in_ms <= cur_beat.tick_ms;
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // receiver, with a recurring long hold-off
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            out_rdy <= 1'b0;
        end else if (cycle_cnt % 2000 == 700) begin
            hold_cnt = 80;
            out_rdy <= 1'b0;
        end else begin
            out_rdy <= calm || $urandom_range(0, 99) >= 21;
        end
    end

    // input beat prediction and result check
    always @(posedge i_clk) begin
        beat_taken = i_rst_n && in_vld && o_in_ready;
        if (beat_taken) begin
            parse_sensor_beat('{in_cmd, in_byte, in_ms}, want);
            predicted_reports.push_back(want);
        end
        if (i_rst_n && o_out_valid && out_rdy) begin
            got = '{o_frame_done, o_black_mask, o_line_mask, o_frame_count, o_data_fresh};
            if (predicted_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycle_cnt);
            end else begin
                want = predicted_reports.pop_front();
                if (got.frame_done !== want.frame_done || got.black_mask !== want.black_mask ||
                        got.line_mask !== want.line_mask || got.frame_count !== want.frame_count ||
                        got.data_fresh !== want.data_fresh) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch cycle %0d: exp done=%b black=%h line=%h cnt=%0d ",
                                  "fresh=%b, got done=%b black=%h line=%h cnt=%0d fresh=%b"},
                            cycle_cnt, want.frame_done, want.black_mask, want.line_mask,
                            want.frame_count, want.data_fresh, got.frame_done, got.black_mask,
                            got.line_mask, got.frame_count, got.data_fresh);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
